@@ rtl/murmur3_hash32_stream_unit_macros.svh @@
// Assertion macros shared by the hash stream unit modules.
`ifndef MURMUR3_HASH32_STREAM_UNIT_MACROS_SVH
`define MURMUR3_HASH32_STREAM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every rising clock edge outside reset
`define M3H_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("m3h assertion failed");
// Check a consequence in the same cycle
`define M3H_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("m3h assertion failed");
// Check a consequence in the following cycle
`define M3H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("m3h assertion failed");
`else
`define M3H_ASSERT(lbl, clk, rst_n, cond)
`define M3H_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define M3H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/m3h_pkg.sv @@
// Constants, command types and helpers of the hash stream unit.
`default_nettype none
package m3h_pkg;

	localparam logic [31:0] C1         = 32'hcc9e2d51;
	localparam logic [31:0] C2         = 32'h1b873593;
	localparam logic [31:0] MIX_ADD    = 32'he6546b64;
	localparam logic [31:0] FMIX1      = 32'h85ebca6b;
	localparam logic [31:0] FMIX2      = 32'hc2b2ae35;
	localparam logic [31:0] SEED_RESET = 32'hEE6B27EB;

	localparam int ROT_K   = 15;
	localparam int ROT_H   = 13;
	localparam int SHR_AV1 = 16;
	localparam int SHR_AV2 = 13;

	// Default depth of the command queue between front and back
	localparam int unsigned Q_DEPTH_DEFAULT = 4;

	// One unit of work for the back end
	typedef struct packed {
		logic        do_mix;
		logic        do_final;
		logic        first;
		logic        tail_nz;
		logic [31:0] block;
		logic [23:0] tail;
		logic [31:0] length;
		logic [31:0] seed;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

endpackage
`default_nettype wire

@@ rtl/m3h_front.sv @@
// Front end: accepts bytes, packs blocks and issues mix and finish commands.
`default_nettype none
module m3h_front import m3h_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        last_byte,
	input  wire logic [31:0] seed,
	input  wire q_status_t   q_status,
	output logic             q_push,
	output cmd_t             q_cmd
);

	logic [23:0] partial_q;
	logic [1:0]  cnt_q;
	logic [31:0] length_q;
	logic        in_string_q;
	logic        mix_sent_q;
	logic [31:0] string_seed_q;

	logic        accept;
	logic        mix;
	logic [23:0] partial_next;
	logic [1:0]  cnt_next;
	logic [31:0] length_next;

	// Accept whenever the queue has room
	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign mix      = byte_valid && (cnt_q == 2'd3);

	// Pack the byte little-endian into the partial block
	always_comb begin
		partial_next = partial_q;
		cnt_next     = cnt_q;
		if (byte_valid) begin
			case (cnt_q)
				2'd0:    partial_next = {16'd0, data_byte};
				2'd1:    partial_next = {8'd0, data_byte, partial_q[7:0]};
				2'd2:    partial_next = {data_byte, partial_q[15:0]};
				default: partial_next = '0;
			endcase
			cnt_next = cnt_q + 2'd1;
		end
	end

	assign length_next = length_q + {31'd0, byte_valid};

	// Build the command for this item
	always_comb begin
		q_cmd.do_mix   = mix;
		q_cmd.do_final = last_byte;
		q_cmd.first    = !mix_sent_q;
		q_cmd.tail_nz  = (cnt_next != 2'd0);
		q_cmd.block    = {data_byte, partial_q};
		q_cmd.tail     = partial_next;
		q_cmd.length   = length_next;
		q_cmd.seed     = in_string_q ? string_seed_q : seed;
	end

	assign q_push = accept && (mix || last_byte);

	// Advance the string state; drop it all at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			cnt_q       <= '0;
			length_q    <= '0;
			in_string_q <= 1'b0;
			mix_sent_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				partial_q   <= '0;
				cnt_q       <= '0;
				length_q    <= '0;
				in_string_q <= 1'b0;
				mix_sent_q  <= 1'b0;
			end else begin
				partial_q <= partial_next;
				cnt_q     <= cnt_next;
				length_q  <= length_next;
				if (byte_valid) begin
					in_string_q <= 1'b1;
				end
				if (mix) begin
					mix_sent_q <= 1'b1;
				end
			end
		end
	end

	// Capture the seed on the first byte of a string
	always_ff @(posedge clk) begin
		if (accept && byte_valid && !in_string_q) begin
			string_seed_q <= seed;
		end
	end

endmodule
`default_nettype wire

@@ rtl/m3h_queue.sv @@
// Command queue between front and back end.
`default_nettype none
`include "murmur3_hash32_stream_unit_macros.svh"
module m3h_queue import m3h_pkg::*; #(
	parameter int unsigned DEPTH = Q_DEPTH_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	input  wire logic  pop,
	output cmd_t       head,
	output q_status_t  status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_P  = AW'(DEPTH - 1);
	localparam logic [AW-1:0] PTR_ONE = AW'(1);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == DEPTH_C);
	assign status.empty = (count_q == '0);

	// Store a pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	`M3H_ASSERT(a_count_bound, clk, arst_n, count_q <= DEPTH_C)
	`M3H_ASSERT(a_no_overflow, clk, arst_n, !(push && status.full))
	`M3H_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, count_q != '0)

endmodule
`default_nettype wire

@@ rtl/m3h_back.sv @@
// Back end: block mix and final avalanche on one shared multiplier.
`default_nettype none
`include "murmur3_hash32_stream_unit_macros.svh"
module m3h_back import m3h_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        q_head,
	input  wire q_status_t   q_status,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      hash_value
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M1   = 4'd1;
	localparam logic [3:0] ST_M2   = 4'd2;
	localparam logic [3:0] ST_M3   = 4'd3;
	localparam logic [3:0] ST_F1   = 4'd4;
	localparam logic [3:0] ST_F2   = 4'd5;
	localparam logic [3:0] ST_F3   = 4'd6;
	localparam logic [3:0] ST_F4   = 4'd7;
	localparam logic [3:0] ST_F5   = 4'd8;
	localparam logic [3:0] ST_F6   = 4'd9;

	logic [3:0]  state_q;
	cmd_t        cmd_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] product;
	logic [31:0] h_rot;
	logic [31:0] h_mixed;
	logic [31:0] fold;
	logic [31:0] fold_av;
	logic        slot_free;

	assign q_pop      = (state_q == ST_IDLE) && !q_status.empty;
	assign slot_free  = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign hash_value = out_data_q;

	// Select multiplier operands by step
	always_comb begin
		case (state_q)
			ST_M1: begin
				mul_a = cmd_q.block;
				mul_b = C1;
			end
			ST_M2, ST_F2: begin
				mul_a = rotl32(k_q, ROT_K);
				mul_b = C2;
			end
			ST_F1: begin
				mul_a = {8'd0, cmd_q.tail};
				mul_b = C1;
			end
			ST_F4: begin
				mul_a = k_q;
				mul_b = FMIX1;
			end
			ST_F5: begin
				mul_a = k_q ^ (k_q >> SHR_AV2);
				mul_b = FMIX2;
			end
			default: begin
				mul_a = k_q;
				mul_b = C1;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	// Mix a scrambled block into the hash: rotate, times five, add
	assign h_rot   = rotl32(h_q ^ k_q, ROT_H);
	assign h_mixed = (h_rot << 2) + h_rot + MIX_ADD;

	// Fold in tail and length, then the first avalanche shift
	assign fold    = h_q ^ (cmd_q.tail_nz ? k_q : 32'd0) ^ cmd_q.length;
	assign fold_av = fold ^ (fold >> SHR_AV1);

	// Step the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result when the last step finds the slot free, drop it once taken
			if ((state_q == ST_F6) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= q_head.do_mix ? ST_M1 : ST_F1;
					end
				end
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= cmd_q.do_final ? ST_F1 : ST_IDLE;
				ST_F1:   state_q <= ST_F2;
				ST_F2:   state_q <= ST_F3;
				ST_F3:   state_q <= ST_F4;
				ST_F4:   state_q <= ST_F5;
				ST_F5:   state_q <= ST_F6;
				ST_F6: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the working values
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					cmd_q <= q_head;
					if (q_head.first) begin
						h_q <= q_head.seed;
					end
				end
			end
			ST_M1, ST_M2, ST_F1, ST_F2, ST_F4, ST_F5: k_q <= product;
			ST_M3: h_q <= h_mixed;
			ST_F3: k_q <= fold_av;
			ST_F6: begin
				if (slot_free) begin
					out_data_q <= k_q ^ (k_q >> SHR_AV1);
				end
			end
			default: ;
		endcase
	end

	`M3H_ASSERT_IMPL(a_mix_order, clk, arst_n, state_q == ST_M3, $past(state_q) == ST_M2)
	`M3H_ASSERT_NEXT(a_hold_result, clk, arst_n, (state_q == ST_F6) && !slot_free, (state_q == ST_F6) && $stable(k_q))
	`M3H_ASSERT_IMPL(a_out_from_final, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_F6)

endmodule
`default_nettype wire

@@ rtl/murmur3_hash32_stream_unit.sv @@
// Throughput: one byte item per cycle while the command queue has room; the
// back end runs each 32-bit block through M1, M2 and M3 before the next pop.
// Result path: with the back end idle, the last item's command leaves the queue and
// steps F1 to F6, after M1 to M3 when it completes a block; then m_axis_tvalid rises.
// Reset (arst_n low) clears all control state and loads the seed 0xEE6B27EB.
// Top level of the streaming 32-bit hash unit.
`default_nettype none
module murmur3_hash32_stream_unit import m3h_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] byte_valid
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] hash_value
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] seed_q;
	logic        q_push;
	logic        q_pop;
	cmd_t        push_cmd;
	cmd_t        head_cmd;
	q_status_t   q_status;

	// Seed register, writable at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	m3h_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.byte_valid (s_axis_tuser[0]),
		.last_byte  (s_axis_tlast),
		.seed       (seed_q),
		.q_status   (q_status),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	m3h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.status   (q_status)
	);

	m3h_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (head_cmd),
		.q_status   (q_status),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.hash_value (m_axis_tdata)
	);

endmodule
`default_nettype wire

@@ tb/murmur3_hash32_stream_unit_test.sv @@
// Self-checking testbench for the streaming 32-bit MurmurHash3 unit.
`default_nettype none
module murmur3_hash32_stream_unit_test;
	import m3h_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 2;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 250;

	// Hash constants, kept here so the predictor stands on its own
	localparam logic [31:0] K_MUL1   = 32'hcc9e2d51;
	localparam logic [31:0] K_MUL2   = 32'h1b873593;
	localparam logic [31:0] H_ADD    = 32'he6546b64;
	localparam logic [31:0] H_MUL    = 32'd5;
	localparam logic [31:0] AV_MUL1  = 32'h85ebca6b;
	localparam logic [31:0] AV_MUL2  = 32'hc2b2ae35;
	localparam logic [31:0] SEED_DEF = 32'hEE6B27EB;
	localparam int          K_ROT    = 15;
	localparam int          H_ROT    = 13;

	typedef enum int {HASH_OK, HASH_UNEXPECTED, HASH_MISMATCH} hash_check_t;

	// Running hash of the current string and the hashes still owed by the unit
	class string_hasher_t;
		logic [31:0] seed;
		logic [31:0] acc;
		logic [31:0] tail;
		logic [1:0]  tail_cnt;
		logic [31:0] len;
		bit          open;
		logic [31:0] pending_hashes[$];

		function new();
			seed = SEED_DEF;
			restart();
		endfunction

		function void restart();
			acc = seed;
			tail = '0;
			tail_cnt = '0;
			len = '0;
			open = 1'b0;
		endfunction

		function logic [31:0] rol(input logic [31:0] x, input int r);
			return (x << r) | (x >> (32 - r));
		endfunction

		function logic [31:0] scramble_block(input logic [31:0] k);
			k = k * K_MUL1;
			k = rol(k, K_ROT);
			return k * K_MUL2;
		endfunction

		// A new seed reloads the hash only when no string is open
		function void load_seed(input logic [31:0] value);
			seed = value;
			if (!open)
				acc = seed;
		endfunction

		function void take_item(input logic [7:0] b, input logic valid, input logic last);
			logic [31:0] h;
			if (valid) begin
				open = 1'b1;
				len = len + 32'd1;
				if (tail_cnt == 2'd3) begin
					acc ^= scramble_block(tail | ({24'd0, b} << 24));
					acc = rol(acc, H_ROT) * H_MUL + H_ADD;
					tail = '0;
					tail_cnt = '0;
				end else begin
					tail |= {24'd0, b} << (8 * tail_cnt);
					tail_cnt = tail_cnt + 2'd1;
				end
			end
			if (last) begin
				h = acc;
				if (tail_cnt != 2'd0)
					h ^= scramble_block(tail);
				h ^= len;
				h ^= h >> 16;
				h = h * AV_MUL1;
				h ^= h >> 13;
				h = h * AV_MUL2;
				h ^= h >> 16;
				pending_hashes.push_back(h);
				restart();
			end
		endfunction

		function int pending();
			return pending_hashes.size();
		endfunction

		function hash_check_t check_hash(input logic [31:0] got, output logic [31:0] want);
			want = '0;
			if (pending_hashes.size() == 0)
				return HASH_UNEXPECTED;
			want = pending_hashes.pop_front();
			return (got === want) ? HASH_OK : HASH_MISMATCH;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
	logic [0:0]  s_axis_tuser = '0;    // [0] byte_valid
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [31:0] hash_value
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int err_count = 0;

	string_hasher_t hasher = new();

	murmur3_hash32_stream_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #(HALF_PERIOD) clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	// Offer one item, idling first as the current phase asks
	task automatic send_item(input logic [7:0] b, input logic valid, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= valid;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		hasher.take_item(b, valid, last);
	endtask

	// Wait until every hash has arrived and the back end has settled
	task automatic wait_idle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (hasher.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		hasher.load_seed(value);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Random strings, some ended by an empty marker, with stray idle items
	task automatic send_strings(input int n_items, input int max_len);
		int counted;
		int slen;
		bit marker_end;
		counted = 0;
		while (counted < n_items) begin
			slen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(max_len);
			marker_end = (slen == 0) || ($urandom_range(6) == 0);
			for (int i = 0; i < slen; i++) begin
				if ($urandom_range(19) == 0)
					send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				send_item(pick_byte(), 1'b1, (i == slen - 1) && !marker_end);
				counted++;
			end
			if (marker_end) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b1);
				counted++;
			end
		end
	endtask

	// Drive the receiver ready: a long hold when asked, else random stalls
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Check each hash and stop the run when nothing moves for too long
	initial begin
		hash_check_t verdict;
		logic [31:0] want;
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				verdict = hasher.check_hash(m_axis_tdata, want);
				if (verdict == HASH_UNEXPECTED)
					report_error($sformatf("unexpected hash %h", m_axis_tdata));
				else if (verdict == HASH_MISMATCH)
					report_error($sformatf("hash %h, expected %h", m_axis_tdata, want));
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: single bytes at the extremes, empty string, idle item, two- and three-byte strings
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		// Full block completed by the last byte
		send_item(8'h12, 1'b1, 1'b0);
		send_item(8'h34, 1'b1, 1'b0);
		send_item(8'h56, 1'b1, 1'b0);
		send_item(8'h78, 1'b1, 1'b1);
		// Five bytes with an idle item inside the string
		send_item(8'hAA, 1'b1, 1'b0);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hCC, 1'b1, 1'b0);
		send_item(8'h33, 1'b1, 1'b0);
		send_item(8'hF0, 1'b1, 1'b1);
		// Full block closed by an empty end marker
		send_item(8'hDE, 1'b1, 1'b0);
		send_item(8'hAD, 1'b1, 1'b0);
		send_item(8'hBE, 1'b1, 1'b0);
		send_item(8'hEF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		wait_idle();

		// No idling, lowest seed
		write_seed(32'h0000_0000);
		send_strings(PHASE_ITEMS, 12);
		// Leave a string open so the next seed lands mid-string
		send_item(pick_byte(), 1'b1, 1'b0);
		send_item(pick_byte(), 1'b1, 1'b0);
		send_item(pick_byte(), 1'b1, 1'b0);
		wait_idle();

		// Sender mostly idle, highest seed
		write_seed(32'hFFFF_FFFF);
		send_idle_pct = 79;
		send_strings(PHASE_ITEMS, 12);
		wait_idle();

		// Receiver mostly stalled
		write_seed($urandom);
		send_idle_pct = 0;
		stall_pct = 79;
		send_strings(PHASE_ITEMS, 12);
		wait_idle();

		// Light idling on both sides
		write_seed($urandom);
		send_idle_pct = 15;
		stall_pct = 15;
		send_strings(PHASE_ITEMS, 12);
		wait_idle();

		// Long receiver hold with short strings to fill the unit
		write_seed($urandom);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		send_strings(PHASE_ITEMS, 3);
		wait_idle();

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
